### hdl/iolh_pkg.sv
`default_nettype none
package iolh_pkg;

	localparam int TAGS        = 128;
	localparam int TAG_W       = 7;
	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int RING_W      = TAG_W + PTR_W;
	localparam int BINS        = 18;
	localparam int BIN_W       = 5;
	localparam int BINCMP_W    = BIN_W + 1;
	localparam int CNT_W       = 32;
	localparam int TS_W        = 64;
	localparam int LAT_W       = 55;
	localparam int DIVISOR     = 1000;
	localparam int REM_W       = 10;

	// divide by 1000 one 16-bit chunk per cycle, msb chunk first
	localparam int CHUNK_W     = 16;
	localparam int CHUNKS      = TS_W / CHUNK_W;
	localparam int CHUNK_CNT_W = $clog2(CHUNKS);
	localparam int LOG_W       = $clog2(CHUNK_W);
	localparam int PART_W      = REM_W + CHUNK_W;
	localparam int RECIP_SHIFT = PART_W + REM_W;
	localparam int RECIP_W     = 27;
	// ceil(2^36 / 1000), exact quotient for any 26-bit partial dividend
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(68719477);
	localparam int PROD_W      = PART_W + RECIP_W;
	localparam int STEP_W      = CHUNK_CNT_W + LOG_W;

	typedef enum logic [1:0] {
		OP_ISSUE    = 2'd0,
		OP_COMPLETE = 2'd1,
		OP_READ     = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_FETCH,
		S_DIVIDE,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic [PTR_W-1:0]  wp;
		logic [PTR_W-1:0]  rp;
		logic [FILL_W-1:0] fill;
	} qptr_t;

	typedef struct packed {
		logic capture;
		logic push;
		logic pop;
		logic finish_pre;
		logic load_div;
		logic div_step;
		logic finish_post;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic div_last;
	} dp_sts_t;

endpackage
`default_nettype wire

### hdl/iolh_div.sv
`default_nettype none
module iolh_div import iolh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic              step,
	input  wire logic [TS_W-1:0]   dividend,
	output logic      [TS_W-1:0]   quotient,
	output logic                   found,
	output logic      [STEP_W-1:0] msb_pos,
	output logic                   last
);

	logic [TS_W-1:0]        dvd_q;
	logic [REM_W-1:0]       rem_q;
	logic [CHUNK_CNT_W-1:0] cnt_q;
	logic                   found_q;
	logic [STEP_W-1:0]      pos_q;
	logic [PART_W-1:0]      part;
	logic [PROD_W-1:0]      prod;
	logic [CHUNK_W-1:0]     qd;
	logic [PART_W-1:0]      back;
	logic [PART_W-1:0]      rem_full;
	logic [REM_W-1:0]       rem_nx;
	logic [LOG_W-1:0]       qd_log;

	// one quotient chunk per cycle while step is high, by reciprocal multiply; chunks shift into the dividend register
	always_comb begin
		part     = {rem_q, dvd_q[TS_W-1 -: CHUNK_W]};
		prod     = PROD_W'(part) * PROD_W'(RECIP);
		qd       = prod[RECIP_SHIFT +: CHUNK_W];
		back     = PART_W'(qd) * PART_W'(DIVISOR);
		rem_full = part - back;
		rem_nx   = rem_full[REM_W-1:0];
		qd_log   = '0;
		for (int i = 0; i < CHUNK_W; i++)
			if (qd[i])
				qd_log = LOG_W'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else if (load) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CHUNK_CNT_W'(1);
			// first nonzero quotient chunk gives floor log2
			if (qd != '0 && !found_q) begin
				found_q <= 1'b1;
				pos_q   <= {~cnt_q, qd_log};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[TS_W-CHUNK_W-1:0], qd};
			rem_q <= rem_nx;
		end
	end

	assign quotient = dvd_q;
	assign found    = found_q;
	assign msb_pos  = pos_q;
	assign last     = (cnt_q == '1);

endmodule
`default_nettype wire

### hdl/iolh_datapath.sv
`default_nettype none
module iolh_datapath import iolh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	input  wire logic [1:0]        op,
	input  wire logic [TAG_W-1:0]  tag,
	input  wire logic [TS_W-1:0]   timestamp_ns,
	input  wire logic [BIN_W-1:0]  bin_select,
	output logic                   done,
	output logic [1:0]             status,
	output logic [LAT_W-1:0]       latency_us,
	output logic [BIN_W-1:0]       bin_index,
	output logic [CNT_W-1:0]       bin_count
);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	op_t              op_q;
	logic [TAG_W-1:0] tag_q;
	logic [TS_W-1:0]  ts_q;
	logic [BIN_W-1:0] sel_q;

	qptr_t            ptr_mem [TAGS];
	qptr_t            ptr_rd_q;
	logic [TAGS-1:0]  ptr_vld_q;
	logic             vld_rd_q;
	qptr_t            cur_ptr;
	qptr_t            ptr_wr;
	logic             ptr_we;

	logic [TS_W-1:0]  ring_mem [1 << RING_W];
	logic [TS_W-1:0]  ring_rd_q;

	logic [CNT_W-1:0] bin_cnt_q [BINS];

	logic [TS_W-1:0]   quotient;
	logic              found;
	logic [STEP_W-1:0] msb_pos;
	logic              div_last;

	logic              lat_big;
	logic [BIN_W-1:0]  bin;
	logic              bin_ok;
	logic              sel_ok;
	logic [CNT_W-1:0]  bin_inc;

	logic              done_q;
	status_t           status_q;
	logic [LAT_W-1:0]  lat_q;
	logic [BIN_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(op);
			tag_q <= tag;
			ts_q  <= timestamp_ns;
			sel_q <= bin_select;
		end
	end

	// per-tag pointer store, read on transfer so the lookup cycle sees it
	always_ff @(posedge clk) begin
		if (cmd.capture)
			ptr_rd_q <= ptr_mem[tag];
		if (ptr_we)
			ptr_mem[tag_q] <= ptr_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_vld_q <= '0;
			vld_rd_q  <= 1'b0;
		end else begin
			if (cmd.capture)
				vld_rd_q <= ptr_vld_q[tag];
			if (ptr_we)
				ptr_vld_q[tag_q] <= 1'b1;
		end
	end

	// an entry never written reads as an empty queue
	assign cur_ptr = vld_rd_q ? ptr_rd_q : '0;
	assign ptr_we  = cmd.push || cmd.pop;

	always_comb begin
		ptr_wr = cur_ptr;
		if (cmd.push) begin
			ptr_wr.wp   = ptr_next(cur_ptr.wp);
			ptr_wr.fill = cur_ptr.fill + FILL_W'(1);
		end else if (cmd.pop) begin
			ptr_wr.rp   = ptr_next(cur_ptr.rp);
			ptr_wr.fill = cur_ptr.fill - FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			ring_mem[{tag_q, cur_ptr.wp}] <= ts_q;
		if (cmd.pop)
			ring_rd_q <= ring_mem[{tag_q, cur_ptr.rp}];
	end

	iolh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load_div),
		.step     (cmd.div_step),
		.dividend (ts_q - ring_rd_q),
		.quotient (quotient),
		.found    (found),
		.msb_pos  (msb_pos),
		.last     (div_last)
	);

	always_comb begin
		sts.op       = op_q;
		sts.full     = cur_ptr.fill >= FILL_W'(QUEUE_DEPTH);
		sts.empty    = cur_ptr.fill == '0;
		sts.div_last = div_last;
	end

	// a zero quotient bins as one, i.e. bin zero
	always_comb begin
		lat_big = found && msb_pos[STEP_W-1];
		bin     = found ? msb_pos[BIN_W-1:0] : '0;
		bin_ok  = !lat_big && ({1'b0, bin} < BINCMP_W'(BINS));
		sel_ok  = {1'b0, sel_q} < BINCMP_W'(BINS);
		bin_inc = bin_cnt_q[bin] + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BINS; i++)
				bin_cnt_q[i] <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish_pre || cmd.finish_post;
			if (cmd.finish_post && bin_ok)
				bin_cnt_q[bin] <= bin_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_pre) begin
			lat_q <= '0;
			idx_q <= sel_q;
			cnt_q <= (op_q == OP_READ && sel_ok) ? bin_cnt_q[sel_q] : '0;
			case (op_q)
				OP_ISSUE: begin
					status_q <= sts.full ? STAT_FULL : STAT_OK;
				end
				OP_COMPLETE: begin
					status_q <= STAT_EMPTY;
				end
				OP_READ: begin
					status_q <= sel_ok ? STAT_OK : STAT_RANGE;
				end
				default: begin
					status_q <= STAT_OK;
				end
			endcase
		end else if (cmd.finish_post) begin
			lat_q <= quotient[LAT_W-1:0];
			if (lat_big) begin
				status_q <= STAT_RANGE;
				idx_q    <= '1;
				cnt_q    <= '0;
			end else if (!bin_ok) begin
				status_q <= STAT_RANGE;
				idx_q    <= bin;
				cnt_q    <= '0;
			end else begin
				status_q <= STAT_OK;
				idx_q    <= bin;
				cnt_q    <= bin_inc;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign latency_us = lat_q;
	assign bin_index  = idx_q;
	assign bin_count  = cnt_q;

endmodule
`default_nettype wire

### hdl/iolh_ctrl.sv
`default_nettype none
module iolh_ctrl import iolh_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_nx = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (sts.op == OP_COMPLETE && !sts.empty)
					state_nx = S_FETCH;
				else
					state_nx = S_IDLE;
			end
			S_FETCH: begin
				state_nx = S_DIVIDE;
			end
			S_DIVIDE: begin
				if (sts.div_last)
					state_nx = S_FINISH;
			end
			S_FINISH: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			S_LOOKUP: begin
				case (sts.op)
					OP_ISSUE: begin
						cmd.push       = !sts.full;
						cmd.finish_pre = 1'b1;
					end
					OP_COMPLETE: begin
						cmd.pop        = !sts.empty;
						cmd.finish_pre = sts.empty;
					end
					default: begin
						cmd.finish_pre = 1'b1;
					end
				endcase
			end
			S_FETCH: begin
				cmd.load_div = 1'b1;
			end
			S_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			S_FINISH: begin
				cmd.finish_post = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

### hdl/io_latency_histogram.sv
`default_nettype none
// Latency histogram fed by per-tag timestamp queues. An item is taken when start is high
// and busy is low; its single result appears on the result ports, marked by done for
// exactly one cycle, and cannot be held off. For issue, read and unused ops, and for a
// complete on an empty queue, the per-tag pointer store is read on transfer and the lookup
// state registers the result, updating the store for an issue that is not full. A complete
// that pops goes through pointer lookup together with the ring memory read, the 64-bit
// subtract into the divider, the divide by 1000 (16 quotient bits per cycle by reciprocal
// multiplication, which also finds floor log2 from the first nonzero quotient chunk), then
// the bin update together with the result register. A new item can be taken in the cycle
// done is high. The queue memory needs no clearing pass; pointers and bins reset at once.
module io_latency_histogram import iolh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [TAG_W-1:0]  tag,
	input  wire logic [TS_W-1:0]   timestamp_ns,
	input  wire logic [BIN_W-1:0]  bin_select,
	output logic                   done,
	output logic [1:0]             status,
	output logic [LAT_W-1:0]       latency_us,
	output logic [BIN_W-1:0]       bin_index,
	output logic [CNT_W-1:0]       bin_count
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	iolh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	iolh_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.tag          (tag),
		.timestamp_ns (timestamp_ns),
		.bin_select   (bin_select),
		.done         (done),
		.status       (status),
		.latency_us   (latency_us),
		.bin_index    (bin_index),
		.bin_count    (bin_count)
	);

	// result only once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// an issue transfer gives its result once the lookup state has registered it
	a_issue_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_ISSUE) |-> ##2 done)
		else $error("issue result missing");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	// a nonzero count only comes with an ok status
	a_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bin_count != '0) |-> status == STAT_OK)
		else $error("count with error status");

endmodule
`default_nettype wire
